// File: rtl/core/mhks_pkg.sv
package mhks_pkg;

  // request action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TEST   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
  } mhks_req_t;

  typedef struct packed {
    logic       found;
    logic [6:0] position;
    logic [6:0] occupancy;
    logic       overflow;
  } mhks_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_FIND_BACK,
    ST_DISPATCH,
    ST_LAST_RD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_DONE
  } mhks_state_e;

endpackage

// File: rtl/core/min_heap_key_set_top.sv
// Set of unsigned keys held in a one-based binary min-heap.
// Request channel (in_valid_i / in_ready_o / in_req_i): one beat carries an
// action (insert if absent, remove if present, test) and a key, taken in its
// low KEY_WIDTH bits. Response channel (out_valid_o / out_ready_i /
// out_rsp_o): one beat per request with found, position (slot, 0 if absent),
// occupancy after the request and overflow (insert refused, heap full).
// One request at a time through a small sequencer around a
// single-port key RAM (registered read) and one shared magnitude comparator.
//   lookup : one read and one compare per visited slot, plus a step for
//            each probe past the last slot
//   insert : one parent read and compare per level climbed, then the key is written
//   remove : fetch the last entry and check its parent, then sift up level
//            by level, or down with up to two child reads per level
//   plus dispatch, response load and the idle accept state per request.
// The RAM port is the bottleneck: one key read per cycle at most.
// in_ready_o is high only while the sequencer is idle. The response sits in
// an output register; the next request is accepted while it still waits, and
// a later result is held in the sequencer until the receiver takes the
// earlier beat, so a stalled receiver loses nothing.
// Reset clears the occupancy and the control state; the key RAM is left as is.
module min_heap_key_set_top #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mhks_pkg::mhks_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mhks_pkg::mhks_rsp_t out_rsp_o
);
  import mhks_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);      // occupancy width
  localparam int IW = $clog2(2 * CAPACITY + 1);  // slot index, holds 2*i
  localparam int AW = $clog2(CAPACITY);          // RAM address

  mhks_state_e state_q, state_d;

  logic [1:0]           act_q, act_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] val_q, val_d;      // entry being sifted
  logic [KEY_WIDTH-1:0] child_q, child_d;  // smaller child seen so far
  logic [IW-1:0]        i_q, i_d;
  logic [IW-1:0]        ci_q, ci_d;
  logic [IW-1:0]        pos_q, pos_d;
  logic [SW-1:0]        size_q, size_d;
  logic                 first_q, first_d;  // remove: first step of sift-up
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  mhks_rsp_t            out_q, out_d;

  // key RAM
  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rdata_q;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        raddr, waddr;
  logic [KEY_WIDTH-1:0] wdata;

  // shared comparator
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_lt, cmp_eq;

  logic [KEY_WIDTH+31:0] key_ext;
  logic [IW-1:0]         i_m1, par_m1, ci_p1, size_ext, i_x2, ci_dn;
  logic                  i_gt_size, ci_lt_size, cdn_gt_size;
  logic                  is_remove, is_found, full;
  logic                  out_free;
  logic [IW+6:0]         pos_wide;
  logic [SW+6:0]         size_wide;

  assign key_ext    = {{KEY_WIDTH{1'b0}}, in_req_i.key};
  assign size_ext   = IW'(size_q);
  assign i_m1       = i_q - IW'(1);
  assign par_m1     = (i_q >> 1) - IW'(1);
  assign ci_p1      = ci_q + IW'(1);
  assign i_x2       = i_q << 1;
  assign ci_dn      = i_q << 1;
  assign i_gt_size  = i_q > size_ext;
  assign ci_lt_size = ci_q < size_ext;
  assign cdn_gt_size = ci_dn > size_ext;
  assign is_remove  = act_q == ACT_REMOVE;
  assign is_found   = pos_q != '0;
  assign full       = size_q >= SW'(CAPACITY);
  assign out_free   = !out_valid_q || out_ready_i;
  assign pos_wide   = {7'd0, pos_q};
  assign size_wide  = {7'd0, size_q};

  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // comparator operand select
  always_comb begin
    cmp_a = rdata_q;
    cmp_b = key_q;
    case (state_q)
      ST_FIND_CMP: begin
        cmp_a = rdata_q;
        cmp_b = key_q;
      end
      ST_UP_CMP: begin
        cmp_a = val_q;
        cmp_b = rdata_q;
      end
      ST_DN_RIGHT: begin
        cmp_a = rdata_q;
        cmp_b = child_q;
      end
      ST_DN_CMP: begin
        cmp_a = child_q;
        cmp_b = val_q;
      end
      default: begin
        cmp_a = rdata_q;
        cmp_b = key_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FIND_RD;
      end
      ST_FIND_RD: begin
        state_d = i_gt_size ? ST_FIND_BACK : ST_FIND_CMP;
      end
      ST_FIND_CMP: begin
        if (cmp_eq) state_d = ST_DISPATCH;
        else if (cmp_lt) state_d = ST_FIND_RD;
        else state_d = ST_FIND_BACK;
      end
      ST_FIND_BACK: begin
        if (i_q[0]) state_d = ST_FIND_BACK;
        else if (i_q == '0) state_d = ST_DISPATCH;
        else state_d = ST_FIND_RD;
      end
      ST_DISPATCH: begin
        case (act_q)
          ACT_INSERT: state_d = (is_found || full) ? ST_DONE : ST_UP_RD;
          ACT_REMOVE: state_d = is_found ? ST_LAST_RD : ST_DONE;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_LAST_RD: begin
        state_d = (pos_q <= size_ext) ? ST_UP_RD : ST_DONE;
      end
      ST_UP_RD: begin
        if (i_q > IW'(1)) state_d = ST_UP_CMP;
        else if (is_remove && first_q) state_d = ST_DN_RD;
        else state_d = ST_DONE;
      end
      ST_UP_CMP: begin
        if (cmp_lt) state_d = ST_UP_RD;
        else if (is_remove && first_q) state_d = ST_DN_RD;
        else state_d = ST_DONE;
      end
      ST_DN_RD: begin
        state_d = cdn_gt_size ? ST_DONE : ST_DN_LEFT;
      end
      ST_DN_LEFT: begin
        state_d = ci_lt_size ? ST_DN_RIGHT : ST_DN_CMP;
      end
      ST_DN_RIGHT: begin
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_d = cmp_lt ? ST_DN_RD : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    child_d     = child_q;
    i_d         = i_q;
    ci_d        = ci_q;
    pos_d       = pos_q;
    size_d      = size_q;
    first_d     = first_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    raddr       = i_m1[AW-1:0];
    wr_en       = 1'b0;
    waddr       = i_m1[AW-1:0];
    wdata       = val_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d = in_req_i.action;
          key_d = key_ext[KEY_WIDTH-1:0];
          i_d   = IW'(1);
          pos_d = '0;
          ovf_d = 1'b0;
        end
      end
      ST_FIND_RD: begin
        if (i_gt_size) i_d = i_q >> 1;
        else rd_en = 1'b1;
      end
      ST_FIND_CMP: begin
        if (cmp_eq) pos_d = i_q;
        else if (cmp_lt) i_d = i_x2;
      end
      ST_FIND_BACK: begin
        if (i_q[0]) i_d = i_q >> 1;
        else if (i_q != '0) i_d = i_q + IW'(1);
      end
      ST_DISPATCH: begin
        case (act_q)
          ACT_INSERT: begin
            if (!is_found) begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                size_d  = size_q + SW'(1);
                i_d     = size_ext + IW'(1);
                val_d   = key_q;
                first_d = 1'b0;
              end
            end
          end
          ACT_REMOVE: begin
            if (is_found) begin
              rd_en  = 1'b1;
              raddr  = AW'(size_q - SW'(1));
              size_d = size_q - SW'(1);
            end
          end
          default: ;
        endcase
      end
      ST_LAST_RD: begin
        val_d   = rdata_q;
        i_d     = pos_q;
        first_d = 1'b1;
      end
      ST_UP_RD: begin
        if (i_q > IW'(1)) begin
          rd_en = 1'b1;
          raddr = par_m1[AW-1:0];
        end else if (!(is_remove && first_q)) begin
          wr_en = 1'b1;
        end
      end
      ST_UP_CMP: begin
        if (cmp_lt) begin
          wr_en   = 1'b1;
          wdata   = rdata_q;
          i_d     = i_q >> 1;
          first_d = 1'b0;
        end else if (!(is_remove && first_q)) begin
          wr_en = 1'b1;
        end
      end
      ST_DN_RD: begin
        ci_d = ci_dn;
        if (cdn_gt_size) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
          raddr = AW'(ci_dn - IW'(1));
        end
      end
      ST_DN_LEFT: begin
        child_d = rdata_q;
        if (ci_lt_size) begin
          rd_en = 1'b1;
          raddr = ci_q[AW-1:0];
        end
      end
      ST_DN_RIGHT: begin
        if (cmp_lt) begin
          child_d = rdata_q;
          ci_d    = ci_p1;
        end
      end
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wdata = child_q;
          i_d   = ci_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.found     = is_found;
          out_d.position  = pos_wide[6:0];
          out_d.occupancy = size_wide[6:0];
          out_d.overflow  = ovf_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    key_q   <= key_d;
    val_q   <= val_d;
    child_q <= child_d;
    i_q     <= i_d;
    ci_q    <= ci_d;
    pos_q   <= pos_d;
    first_q <= first_d;
    ovf_q   <= ovf_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SW'(CAPACITY))
    else $error("occupancy above capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && ovf_q) |-> (full && !is_found))
    else $error("overflow without full heap");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISPATCH && is_remove && is_found)
      |=> size_q == $past(size_q) - SW'(1))
    else $error("remove did not shrink heap");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while busy");
`endif

endmodule
